// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked implication checks, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/irpd_pkg.sv -----
// ----------------------------------------------------------------------------
// irpd_pkg
// shared types and constants of the ir pulse distance receiver
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

  localparam int WORD_W    = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd3;

  // reset values
  localparam logic [CFG_W-1:0] RST_MAX_INTERVAL   = 16'd8000;
  localparam logic [CFG_W-1:0] RST_MIN_INTERVAL   = 16'd200;
  localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD  = 16'd1100;
  localparam logic [CFG_W-1:0] RST_ZERO_THRESHOLD = 16'd200;

  typedef struct packed {
    logic [CFG_W-1:0] max_interval;
    logic [CFG_W-1:0] min_interval;
    logic [CFG_W-1:0] one_threshold;
    logic [CFG_W-1:0] zero_threshold;
  } cfg_t;

  typedef struct packed {
    logic              emit;   // the pending beat completes a frame
    logic              busy;   // frame in progress
    logic [WORD_W-1:0] word;   // word after the pending beat
  } dec_status_t;

endpackage

`default_nettype wire

// ----- hdl/irpd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// interval limits and bit thresholds, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_cfg_regs (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [irpd_pkg::CFG_W-1:0]        cfg_wdata,
  output irpd_pkg::cfg_t                    cfg
);
  import irpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_INTERVAL:   cfg_nxt.max_interval   = cfg_wdata;
        REG_MIN_INTERVAL:   cfg_nxt.min_interval   = cfg_wdata;
        REG_ONE_THRESHOLD:  cfg_nxt.one_threshold  = cfg_wdata;
        REG_ZERO_THRESHOLD: cfg_nxt.zero_threshold = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_interval   <= RST_MAX_INTERVAL;
      cfg_r.min_interval   <= RST_MIN_INTERVAL;
      cfg_r.one_threshold  <= RST_ONE_THRESHOLD;
      cfg_r.zero_threshold <= RST_ZERO_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/irpd_decoder.sv -----
// ----------------------------------------------------------------------------
// irpd_decoder
// frame state and one-step edge decode: interval check, bit store, frame end
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_decoder #(
  parameter int FRAME_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  irpd_pkg::cfg_t                    cfg,
  input  wire                               item_level,
  input  wire  [irpd_pkg::TIME_W-1:0]       item_time,
  input  wire                               fire,
  output irpd_pkg::dec_status_t             status
);
  import irpd_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  logic              busy_r,  busy_nxt;
  logic              await_r, await_nxt;
  logic [CNT_W-1:0]  bits_r,  bits_nxt;
  logic [TIME_W-1:0] last_r,  last_nxt;
  logic [WORD_W-1:0] word_r,  word_nxt;

  logic [TIME_W-1:0] span;
  logic              abort;
  logic              is_one;
  logic              is_zero;
  logic [CNT_W-1:0]  bits_after;
  logic [WORD_W-1:0] word_after;
  logic              emit_c;

  // wrapping interval since the previous rising edge
  assign span    = item_time - last_r;
  assign abort   = (span > {16'd0, cfg.max_interval}) || (span < {16'd0, cfg.min_interval});
  assign is_one  = span > {16'd0, cfg.one_threshold};
  assign is_zero = !is_one && (span > {16'd0, cfg.zero_threshold});

  always_comb begin
    word_after = word_r;
    for (int k = 0; k < WORD_W; k++) begin
      if ((is_one || is_zero) && (32'(bits_r) == k)) begin
        word_after[k] = is_one;
      end
    end
  end

  assign bits_after = (is_one || is_zero) ? bits_r + CNT_W'(1) : bits_r;
  assign emit_c     = busy_r && item_level && !await_r && !abort
                      && (32'(bits_after) >= FRAME_BITS);

  always_comb begin
    busy_nxt  = busy_r;
    await_nxt = await_r;
    bits_nxt  = bits_r;
    last_nxt  = last_r;
    word_nxt  = word_r;
    if (fire) begin
      if (!busy_r) begin
        if (!item_level) begin
          busy_nxt  = 1'b1;
          await_nxt = 1'b1;
          bits_nxt  = '0;
          word_nxt  = '0;
        end
      end else if (item_level) begin
        if (await_r) begin
          await_nxt = 1'b0;
          bits_nxt  = '0;
          last_nxt  = item_time;
        end else if (abort) begin
          busy_nxt  = 1'b0;
          await_nxt = 1'b1;
          bits_nxt  = '0;
          word_nxt  = '0;
        end else begin
          bits_nxt = bits_after;
          word_nxt = word_after;
          last_nxt = item_time;
          if (emit_c) begin
            busy_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      await_r <= 1'b0;
      bits_r  <= '0;
      last_r  <= '0;
      word_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      await_r <= await_nxt;
      bits_r  <= bits_nxt;
      last_r  <= last_nxt;
      word_r  <= word_nxt;
    end
  end

  assign status.emit = emit_c;
  assign status.busy = busy_r;
  assign status.word = word_after;

endmodule

`default_nettype wire

// ----- hdl/ir_pulse_distance_receiver_top.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_distance_receiver_top
// pulse distance infrared frame receiver working on timestamped edge beats
// ----------------------------------------------------------------------------
// usage
//   in_*  : one beat per line edge, in_line_level is the level after the edge
//           and in_edge_time a free-running 32-bit tick stamp
//   out_* : one beat per completed frame, first received bit in bit 0
//   cfg_* : plain write port, index 0..3 selects max_interval, min_interval,
//           one_threshold, zero_threshold; write only while idle
// timing
//   a beat lands in the input register, then the decode step and the result
//   register follow; a frame word shows on out_valid once the edge beat that
//   completes it has moved from the input register into the result register
//   throughput is one beat per cycle outside stalls, set by the decoder's
//   single step (one 32-bit subtract and four compares against the limits)
// reset
//   rst_n low clears the frame state and loads the default limits
// stall
//   while a frame word waits on out_ready, beats that produce no word still
//   pass; a beat that completes a frame waits in the input register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ir_pulse_distance_receiver_top #(
  parameter int FRAME_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // edge channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_line_level,
  input  wire  [irpd_pkg::TIME_W-1:0]       in_edge_time,
  // frame channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [irpd_pkg::WORD_W-1:0]       out_frame_word,
  // configuration
  input  wire                               cfg_we,
  input  wire  [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [irpd_pkg::CFG_W-1:0]        cfg_wdata
);
  import irpd_pkg::*;

  cfg_t        cfg;
  dec_status_t status;

  // input register
  logic              s_valid_r, s_valid_nxt;
  logic              s_level_r;
  logic [TIME_W-1:0] s_time_r;

  // result register
  logic              o_valid_r, o_valid_nxt;
  logic [WORD_W-1:0] o_word_r;

  logic fire;
  logic load_out;

  irpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irpd_decoder #(
    .FRAME_BITS (FRAME_BITS)
  ) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_level (s_level_r),
    .item_time  (s_time_r),
    .fire       (fire),
    .status     (status)
  );

  // the staged beat moves on unless it completes a frame and the result
  // register is still occupied
  assign fire     = s_valid_r && (!status.emit || !o_valid_r || out_ready);
  assign load_out = fire && status.emit;
  assign in_ready = !s_valid_r || fire;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_valid && in_ready) begin
      s_valid_nxt = 1'b1;
    end else if (fire) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (load_out) begin
      o_valid_nxt = 1'b1;
    end else if (out_ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_level_r <= in_line_level;
      s_time_r  <= in_edge_time;
    end
    if (load_out) begin
      o_word_r <= status.word;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_frame_word = o_word_r;

  // a completed frame is always captured by the result register
  `ASSERT_NEXT(a_frame_loaded, clk, rst_n, load_out, o_valid_r && (o_word_r == $past(status.word)))
  // completing a frame returns the decoder to idle
  `ASSERT_NEXT(a_idle_after_frame, clk, rst_n, load_out, !status.busy)
  // the input side stalls only behind a blocked frame word
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ready,
               s_valid_r && status.emit && o_valid_r && !out_ready)

endmodule

`default_nettype wire

// ----- tb/irpd_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_frame_checker
// watches the edge and frame channels and the limit writes, decodes each
// accepted edge beat on its own copy of the receiver state and compares every
// frame beat against the oldest word still due
// ----------------------------------------------------------------------------

module irpd_frame_checker #(
  parameter int FRAME_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire                            in_line_level,
  input  wire [irpd_pkg::TIME_W-1:0]     in_edge_time,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire [irpd_pkg::WORD_W-1:0]     out_frame_word,
  input  wire                            cfg_we,
  input  wire [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [irpd_pkg::CFG_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             words_pending
);

  import irpd_pkg::*;

  cfg_t              limits;
  logic              armed;
  logic              need_start;
  int unsigned       bits_done;
  logic [TIME_W-1:0] last_rise;
  logic [WORD_W-1:0] shift_word;
  logic [WORD_W-1:0] frames_due [$];
  int                mismatches = 0;

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns frame check: %s, got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic decode_edge(input logic high, input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] span;
    span = stamp - last_rise;
    if (!armed) begin
      // falling edge arms, rising edge is ignored
      if (!high) begin
        armed      = 1'b1;
        need_start = 1'b1;
        bits_done  = 0;
        shift_word = '0;
      end
    end else if (high) begin
      if (need_start) begin
        need_start = 1'b0;
        bits_done  = 0;
        last_rise  = stamp;
      end else if (span > TIME_W'(limits.max_interval) ||
                   span < TIME_W'(limits.min_interval)) begin
        armed      = 1'b0;
        need_start = 1'b1;
        bits_done  = 0;
        shift_word = '0;
      end else begin
        if (span > TIME_W'(limits.one_threshold)) begin
          if (bits_done < WORD_W) shift_word[bits_done] = 1'b1;
          bits_done++;
        end else if (span > TIME_W'(limits.zero_threshold)) begin
          if (bits_done < WORD_W) shift_word[bits_done] = 1'b0;
          bits_done++;
        end
        last_rise = stamp;
        if (bits_done >= FRAME_BITS) begin
          armed = 1'b0;
          frames_due.push_back(shift_word);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limits.max_interval   = RST_MAX_INTERVAL;
      limits.min_interval   = RST_MIN_INTERVAL;
      limits.one_threshold  = RST_ONE_THRESHOLD;
      limits.zero_threshold = RST_ZERO_THRESHOLD;
      armed      = 1'b0;
      need_start = 1'b0;
      bits_done  = 0;
      last_rise  = '0;
      shift_word = '0;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_INTERVAL:   limits.max_interval   = cfg_wdata;
          REG_MIN_INTERVAL:   limits.min_interval   = cfg_wdata;
          REG_ONE_THRESHOLD:  limits.one_threshold  = cfg_wdata;
          REG_ZERO_THRESHOLD: limits.zero_threshold = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("frame beat with no word due", out_frame_word, '0);
        end else begin
          if (out_frame_word !== frames_due[0])
            report_mismatch("frame_word", out_frame_word, frames_due[0]);
          void'(frames_due.pop_front());
        end
      end
      if (in_valid && in_ready) decode_edge(in_line_level, in_edge_time);
    end
    fail_count    <= mismatches;
    words_pending <= frames_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives timestamped edge beats into the pulse distance receiver under a
// series of interval limits, with random gaps and stalls on both channels;
// a checker beside the block predicts and compares every frame word
// ----------------------------------------------------------------------------

module testbench;

  import irpd_pkg::*;

  localparam int FRAME_BITS      = 16;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 8;     // result path runs through the input and result registers
  localparam int LONG_HOLD       = 300;   // receiver hold-off, long enough to fill the block
  localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles before giving up

  // kinds of rise-to-rise interval the sender can aim for
  typedef enum int {
    SPAN_ONE,
    SPAN_ZERO,
    SPAN_NOBIT,
    SPAN_LONG,
    SPAN_SHORT
  } span_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_line_level;
  logic [TIME_W-1:0]     in_edge_time;
  logic                  out_valid;
  logic                  out_ready;
  logic [WORD_W-1:0]     out_frame_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  int                    fail_count;
  int                    words_pending;

  // sender side bookkeeping
  logic [TIME_W-1:0] tick = '0;   // running tick clock of the stimulus
  logic [31:0]       lim_max  = 32'(RST_MAX_INTERVAL);
  logic [31:0]       lim_min  = 32'(RST_MIN_INTERVAL);
  logic [31:0]       lim_one  = 32'(RST_ONE_THRESHOLD);
  logic [31:0]       lim_zero = 32'(RST_ZERO_THRESHOLD);
  int                edges_sent  = 0;
  int                words_seen  = 0;
  int                quiet_cycles = 0;
  bit                tx_calm     = 1'b0;  // no gaps while set
  bit                rx_hold_req = 1'b0;  // asks the receiver for one long hold-off

  ir_pulse_distance_receiver_top #(
    .FRAME_BITS (FRAME_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_line_level  (in_line_level),
    .in_edge_time   (in_edge_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_word (out_frame_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  irpd_frame_checker #(
    .FRAME_BITS (FRAME_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_line_level  (in_line_level),
    .in_edge_time   (in_edge_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_word (out_frame_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // count frame beats, used to keep the last phase going until enough words came
  always @(posedge clk) begin
    if (out_valid && out_ready) words_seen <= words_seen + 1;
  end

  // watchdog: cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns watchdog: no beat for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // frame receiver: random ready pattern, short stalls mostly, some long ready
  // stretches, and one long hold-off when the stimulus asks for it
  initial begin : rx_side
    int n;
    int r;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        n = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 65) begin
          out_ready <= 1'b1;
          n = $urandom_range(30, 80);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(15, 40);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // one edge beat; returns at the edge where it was accepted, valid still high
  task automatic send_edge(input logic high, input logic [TIME_W-1:0] stamp);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) gap = 0;
    else if (r < 90)       gap = $urandom_range(1, 3);
    else if (r < 98)       gap = $urandom_range(4, 10);
    else                   gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_line_level <= high;
    in_edge_time  <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edges_sent++;
  endtask

  // stop offering beats and wait until every predicted word has been taken,
  // then a few more cycles for beats that produce nothing
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_limits(input logic [CFG_W-1:0] mx, input logic [CFG_W-1:0] mn,
                              input logic [CFG_W-1:0] one, input logic [CFG_W-1:0] zero);
    lim_max  = 32'(mx);
    lim_min  = 32'(mn);
    lim_one  = 32'(one);
    lim_zero = 32'(zero);
    write_reg(REG_MAX_INTERVAL, mx);
    write_reg(REG_MIN_INTERVAL, mn);
    write_reg(REG_ONE_THRESHOLD, one);
    write_reg(REG_ZERO_THRESHOLD, zero);
    cfg_we <= 1'b0;
  endtask

  // interval of the given kind under the current limits; edges of the range
  // are favored, an empty range gives a random 32-bit interval
  function automatic logic [31:0] pick_span(input span_kind_t kind);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] span;
    lo = 32'd1;
    hi = 32'd0;
    case (kind)
      SPAN_ONE: begin
        lo = lim_one + 32'd1;
        hi = lim_max;
      end
      SPAN_ZERO: begin
        lo = (lim_zero + 32'd1 > lim_min) ? lim_zero + 32'd1 : lim_min;
        hi = (lim_one < lim_max) ? lim_one : lim_max;
      end
      SPAN_NOBIT: begin
        lo = lim_min;
        hi = (lim_zero < lim_max) ? lim_zero : lim_max;
      end
      SPAN_LONG: begin
        lo = lim_max + 32'd1;
        hi = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : lo + 32'd600;
      end
      SPAN_SHORT: begin
        if (lim_min != 32'd0) begin
          lo = 32'd0;
          hi = lim_min - 32'd1;
        end
      end
      default: ;
    endcase
    if (lo > hi) begin
      span = $urandom();
    end else begin
      case ($urandom_range(0, 7))
        0:       span = lo;
        1:       span = hi;
        default: span = lo + $urandom_range(0, hi - lo);
      endcase
    end
    return span;
  endfunction

  // arming fall, start rise, then rises carrying random bits; a broken
  // interval ends the frame early, stray falls while busy are mixed in
  task automatic send_frame(input int broken_pct);
    logic [TIME_W-1:0] rise;
    logic [31:0]       span;
    int                stored;
    int                tries;
    int                r;
    tick = tick + $urandom_range(1, 20000);
    if ($urandom_range(0, 19) == 0) tick = $urandom();   // jump anywhere, wrap gets hit
    send_edge(1'b0, tick);
    rise = tick + $urandom_range(0, 9000);
    send_edge(1'b1, rise);
    stored = 0;
    tries  = 0;
    while (stored < FRAME_BITS && tries < 2 * FRAME_BITS) begin
      tries++;
      r = $urandom_range(0, 99);
      if (r < broken_pct) begin
        span  = pick_span(($urandom_range(0, 1) == 1) ? SPAN_LONG : SPAN_SHORT);
        tries = 2 * FRAME_BITS;
      end else if (r < broken_pct + 6) begin
        span = pick_span(SPAN_NOBIT);
      end else begin
        span = pick_span(($urandom_range(0, 1) == 1) ? SPAN_ONE : SPAN_ZERO);
        stored++;
      end
      if ($urandom_range(0, 3) == 0) send_edge(1'b0, rise + (span >> 1));
      rise = rise + span;
      send_edge(1'b1, rise);
    end
    // a rise after the frame finds the receiver idle
    if ($urandom_range(0, 9) == 0) send_edge(1'b1, rise + pick_span(SPAN_ONE));
    tick = rise;
  endtask

  // mostly whole frames, some lone edges at random times; the optional word
  // count keeps it going, with a cap in case words never show up
  task automatic run_traffic(input int n_items, input int broken_pct, input int want_words);
    int stop_at;
    stop_at = edges_sent + n_items;
    while ((edges_sent < stop_at || words_seen < want_words) &&
           edges_sent < stop_at + 3000) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) send_frame(broken_pct);
      else send_edge($urandom_range(0, 1) == 1, $urandom());
    end
    tx_calm = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned       dir_spans [17];
    logic [TIME_W-1:0] rise;
    logic [CFG_W-1:0]  mx;
    logic [CFG_W-1:0]  mn;
    logic [CFG_W-1:0]  zr;
    logic [CFG_W-1:0]  on;
    int                k;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_line_level = 1'b0;
    in_edge_time  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MAX_INTERVAL;
    cfg_wdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset limits (8000 / 200 / 1100 / 200):
    // limit values exactly, one and zero thresholds exactly and one above,
    // an interval equal to the zero threshold that stores no bit
    dir_spans = '{8000, 1101, 1100, 201, 200, 3000, 400, 1200, 900,
                  7999, 202, 1101, 300, 5000, 250, 1800, 700};
    send_edge(1'b1, 32'h0000_0000);          // rise while idle: ignored
    send_edge(1'b0, 32'hFFFF_FFFF);          // fall arms
    rise = 32'hFFFF_E000;                    // start just below the wrap
    send_edge(1'b1, rise);
    for (k = 0; k < 17; k++) begin
      if (k == 3) send_edge(1'b0, rise + 32'd10);   // fall while busy: ignored
      rise = rise + dir_spans[k];
      send_edge(1'b1, rise);
    end
    send_edge(1'b1, rise + 32'd1500);        // idle again, no repeated word
    // one above the longest interval aborts, and that rise does not re-arm
    send_edge(1'b0, 32'h0000_0000);
    send_edge(1'b1, 32'h0000_1000);
    send_edge(1'b1, 32'h0000_1000 + 32'd8001);
    send_edge(1'b1, 32'h0000_1000 + 32'd9500);
    // one below the shortest interval aborts
    send_edge(1'b0, 32'h8000_0000);
    send_edge(1'b1, 32'h8000_0010);
    send_edge(1'b1, 32'h8000_0010 + 32'd199);

    run_traffic(70, 4, 0);

    // long receiver hold-off while whole frames keep coming: the block fills
    // and stalls the edge channel
    rx_hold_req = 1'b1;
    tx_calm     = 1'b1;
    repeat (4) send_frame(0);
    tx_calm     = 1'b0;
    run_traffic(60, 4, 0);
    wait_idle();

    // widest window, zero threshold at its floor
    write_limits(16'hFFFF, 16'h0000, 16'h8000, 16'h0000);
    run_traffic(100, 5, 0);
    wait_idle();

    // zero-width window: only a zero interval survives, and it stores nothing
    write_limits(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    run_traffic(30, 5, 0);
    wait_idle();

    // window squeezed to the top of the range
    write_limits(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFD);
    run_traffic(60, 3, 0);
    wait_idle();

    // shortest above longest: every measured interval aborts
    write_limits(16'd1000, 16'd5000, 16'd3000, 16'd2000);
    run_traffic(30, 5, 0);
    wait_idle();

    // random but ordered limits
    repeat (2) begin
      mx = CFG_W'($urandom_range(2000, 65535));
      mn = CFG_W'($urandom_range(0, mx / 4));
      zr = CFG_W'($urandom_range(mn, mx / 2));
      on = CFG_W'($urandom_range(zr + 1, mx - 1));
      write_limits(mx, mn, on, zr);
      run_traffic(160, 4, 0);
      wait_idle();
    end

    // back to the reset limits; the sender pauses twice until every word is in
    write_limits(RST_MAX_INTERVAL, RST_MIN_INTERVAL, RST_ONE_THRESHOLD, RST_ZERO_THRESHOLD);
    run_traffic(80, 4, 0);
    wait_idle();
    run_traffic(90, 4, 40);
    wait_idle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/irpd_pkg.sv
hdl/irpd_cfg_regs.sv
hdl/irpd_decoder.sv
hdl/ir_pulse_distance_receiver_top.sv
tb/irpd_frame_checker.sv
tb/testbench.sv
